// ----- rtl/psrl_pkg.sv -----
// Shared types, codes and constants of the per-slot event rate limiter.
package psrl_pkg;

    // Field widths of the stream items.
    localparam int SLOT_W  = 3;
    localparam int KIND_W  = 2;
    localparam int MASK_W  = 4;
    localparam int TOKEN_W = 16;
    localparam int COUNT_W = 32;

    // Default sizes of the counter store.
    localparam int DEF_NUM_SLOTS = 8;
    localparam int DEF_NUM_KINDS = 4;

    // Refill value after reset, and the value used when the rate register is zero.
    localparam logic [TOKEN_W-1:0] FALLBACK_RATE = 16'd100;

    // Work queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Command codes on the input tuser.
    localparam logic [1:0] CMD_EVENT  = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_CONFIG = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_RATE = 1'b0;
    localparam logic CFG_MASK = 1'b1;

    typedef enum logic [1:0] {
        OP_EVENT,
        OP_TICK,
        OP_CONFIG
    } t_op;

    typedef enum logic [1:0] {
        RK_VERDICT = 2'd0,
        RK_REPORT  = 2'd1,
        RK_ACK     = 2'd2,
        RK_DONE    = 2'd3
    } t_rkind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EV_RD,
        ST_TK_RD,
        ST_TK_WR,
        ST_CF_WR,
        ST_EMIT
    } t_bstate;

    // One classified command waiting for the back part.
    typedef struct packed {
        t_op               op;
        logic [SLOT_W-1:0] slot;
        logic [KIND_W-1:0] kind;
        logic [MASK_W-1:0] new_mask;
        logic              inherit;
        logic              ev_ok;
        logic              slot_ok;
    } t_work;

    // One result item.
    typedef struct packed {
        t_rkind             rkind;
        logic               allowed;
        logic [SLOT_W-1:0]  slot;
        logic [KIND_W-1:0]  kind;
        logic [COUNT_W-1:0] count;
        logic               last;
    } t_result;

endpackage

// ----- rtl/psrl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module psrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                          i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                          o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- rtl/psrl_front.sv -----
// Front part: accepts commands, classifies them and queues them for the back part.
module psrl_front #(
    parameter int NUM_SLOTS = 8,
    parameter int NUM_KINDS = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [1:0]                  i_command,
    input  logic [psrl_pkg::SLOT_W-1:0] i_slot,
    input  logic [psrl_pkg::KIND_W-1:0] i_kind,
    input  logic [psrl_pkg::MASK_W-1:0] i_new_mask,
    input  logic                        i_inherit,
    output logic                        o_q_valid,
    output psrl_pkg::t_work             o_q_item,
    input  logic                        i_q_pop
);
    import psrl_pkg::*;

    t_work             r_buf [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    t_work w_item;
    logic  w_known;
    logic  w_push;

    always_comb begin
        w_item          = '0;
        w_known         = 1'b1;
        w_item.slot     = i_slot;
        w_item.kind     = i_kind;
        w_item.new_mask = i_new_mask;
        w_item.inherit  = i_inherit;
        w_item.slot_ok  = ({1'b0, i_slot} < 4'(NUM_SLOTS));
        w_item.ev_ok    = w_item.slot_ok && ({1'b0, i_kind} < 3'(NUM_KINDS));
        case (i_command)
            CMD_EVENT:  w_item.op = OP_EVENT;
            CMD_TICK:   w_item.op = OP_TICK;
            CMD_CONFIG: w_item.op = OP_CONFIG;
            default: begin
                // The unused command is taken and dropped.
                w_item.op = OP_EVENT;
                w_known   = 1'b0;
            end
        endcase
    end

    assign o_s_tready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign w_push     = i_s_tvalid && o_s_tready && w_known;
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_item   = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_q_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !i_q_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_push && i_q_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp] <= w_item;
        end
    end
endmodule

// ----- rtl/psrl_back.sv -----
// Back part: carries out events, ticks and slot configuration on the counter store.
module psrl_back #(
    parameter int NUM_SLOTS = 8,
    parameter int NUM_KINDS = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  psrl_pkg::t_work              i_q_item,
    output logic                         o_q_pop,
    input  logic [psrl_pkg::TOKEN_W-1:0] i_refill,
    input  logic [psrl_pkg::MASK_W-1:0]  i_default_mask,
    output logic                         o_out_valid,
    output psrl_pkg::t_result            o_out,
    input  logic                         i_out_ready
);
    import psrl_pkg::*;

    localparam int SW     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int KW     = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;
    localparam int SCW    = $clog2(NUM_SLOTS + 1);
    localparam int AW     = SW + KW;
    localparam int DEPTH  = 1 << AW;
    localparam int WORD_W = TOKEN_W + COUNT_W;

    t_bstate            r_state, n_state;
    logic [SCW-1:0]     r_slot, n_slot;
    logic [KW-1:0]      r_kind, n_kind;
    t_result            r_pend, n_pend;
    logic [MASK_W-1:0]  r_mask [1 << SW];
    logic [DEPTH-1:0]   r_valid;
    logic               r_rd_valid;
    logic               r_out_valid;
    t_result            r_out;

    logic               w_we;
    logic [WORD_W-1:0]  w_wdata;
    logic [AW-1:0]      w_addr;
    logic [AW-1:0]      w_rd_addr;
    logic [WORD_W-1:0]  w_rd_data;
    logic [TOKEN_W-1:0] w_tok;
    logic [COUNT_W-1:0] w_cnt;
    logic               w_mask_we;
    logic [SW-1:0]      w_mask_idx;
    logic [MASK_W-1:0]  w_mask;
    logic               w_emit;
    t_result            w_emit_res;
    logic               w_out_free;

    psrl_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_wr_addr (w_addr),
        .i_wr_data (w_wdata),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Entries never written read as zero tokens and zero count.
    assign w_tok      = r_rd_valid ? w_rd_data[WORD_W-1:COUNT_W] : '0;
    assign w_cnt      = r_rd_valid ? w_rd_data[COUNT_W-1:0] : '0;
    assign w_addr     = {r_slot[SW-1:0], r_kind};
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_mask     = r_mask[w_mask_idx];

    always_comb begin
        n_state    = r_state;
        n_slot     = r_slot;
        n_kind     = r_kind;
        n_pend     = r_pend;
        o_q_pop    = 1'b0;
        w_we       = 1'b0;
        w_wdata    = {i_refill, {COUNT_W{1'b0}}};
        w_rd_addr  = w_addr;
        w_mask_we  = 1'b0;
        w_mask_idx = r_slot[SW-1:0];
        w_emit     = 1'b0;
        w_emit_res = r_pend;
        case (r_state)
            ST_IDLE: begin
                w_mask_idx = SW'(i_q_item.slot);
                w_rd_addr  = {SW'(i_q_item.slot), KW'(i_q_item.kind)};
                if (i_q_valid) begin
                    o_q_pop        = 1'b1;
                    n_slot         = SCW'(i_q_item.slot);
                    n_kind         = KW'(i_q_item.kind);
                    n_pend         = '0;
                    n_pend.slot    = i_q_item.slot;
                    n_pend.last    = 1'b1;
                    case (i_q_item.op)
                        OP_EVENT: begin
                            n_pend.rkind = RK_VERDICT;
                            n_pend.kind  = i_q_item.kind;
                            if (i_q_item.ev_ok && w_mask[i_q_item.kind]) begin
                                n_state = ST_EV_RD;
                            end else begin
                                n_state = ST_EMIT;
                            end
                        end
                        OP_TICK: begin
                            n_pend.rkind = RK_DONE;
                            n_pend.slot  = '0;
                            n_slot       = '0;
                            n_kind       = '0;
                            n_state      = ST_TK_RD;
                        end
                        OP_CONFIG: begin
                            n_pend.rkind = RK_ACK;
                            n_kind       = '0;
                            if (i_q_item.slot_ok) begin
                                w_mask_we = 1'b1;
                                n_state   = ST_CF_WR;
                            end else begin
                                n_state = ST_EMIT;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_EV_RD: begin
                if (w_out_free) begin
                    w_we       = 1'b1;
                    w_emit     = 1'b1;
                    n_state    = ST_IDLE;
                    if (w_tok != '0) begin
                        w_wdata            = {w_tok - 1'b1, w_cnt};
                        w_emit_res.allowed = 1'b1;
                    end else if (w_cnt != '1) begin
                        w_wdata = {w_tok, w_cnt + 1'b1};
                    end else begin
                        w_wdata = {w_tok, w_cnt};
                    end
                end
            end
            ST_TK_RD: begin
                if (r_slot == SCW'(NUM_SLOTS)) begin
                    n_state = ST_EMIT;
                end else if (w_mask == '0) begin
                    n_slot = r_slot + 1'b1;
                end else begin
                    n_state = ST_TK_WR;
                end
            end
            ST_TK_WR: begin
                if (w_cnt == '0 || w_out_free) begin
                    w_we       = 1'b1;
                    w_emit     = (w_cnt != '0);
                    w_emit_res = '{rkind: RK_REPORT, allowed: 1'b0, slot: SLOT_W'(r_slot),
                                   kind: KIND_W'(r_kind), count: w_cnt, last: 1'b0};
                    n_state    = ST_TK_RD;
                    if (r_kind == KW'(NUM_KINDS - 1)) begin
                        n_kind = '0;
                        n_slot = r_slot + 1'b1;
                    end else begin
                        n_kind = r_kind + 1'b1;
                    end
                end
            end
            ST_CF_WR: begin
                w_we = 1'b1;
                if (r_kind == KW'(NUM_KINDS - 1)) begin
                    n_kind  = '0;
                    n_state = ST_EMIT;
                end else begin
                    n_kind = r_kind + 1'b1;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    w_emit  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_slot      <= '0;
            r_kind      <= '0;
            r_valid     <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < (1 << SW); i++) begin
                r_mask[i] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_slot     <= n_slot;
            r_kind     <= n_kind;
            r_rd_valid <= r_valid[w_rd_addr];
            if (w_we) begin
                r_valid[w_addr] <= 1'b1;
            end
            if (w_mask_we) begin
                r_mask[w_mask_idx] <= i_q_item.inherit ? i_default_mask : i_q_item.new_mask;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (w_emit) begin
            r_out <= w_emit_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
endmodule

// ----- rtl/per_slot_event_rate_limiter_top.sv -----
// A valid, enabled event passes the queue and the back sequencer's IDLE and EV_RD states before its
// verdict is registered at the output. A configure of a valid slot writes the store entry of every
// kind of its slot in turn, and a tick reads each slot's mask and visits every kind of each slot
// whose mask is nonzero. The back sequencer takes no new command until the current one is finished.
// Reset (i_rst_n low at a clock edge) clears masks, counters, the queue and the output;
// the rate register returns to 100 and the default mask to zero.
module per_slot_event_rate_limiter_top #(
    parameter int NUM_SLOTS = psrl_pkg::DEF_NUM_SLOTS,
    parameter int NUM_KINDS = psrl_pkg::DEF_NUM_KINDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,  // slot[2:0], kind[4:3], new_mask[8:5], inherit[9], zero
    input  logic [1:0]  i_s_tuser,  // command[1:0]
    // Result stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,  // allowed[0], report_slot[3:1], report_kind[5:4],
                                    // suppressed_count[37:6], zero[39:38]
    output logic [1:0]  o_m_tuser,  // result_kind[1:0]
    output logic        o_m_tlast,  // last
    // Configuration writes: index 0 default_rate, index 1 default_mask.
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import psrl_pkg::*;

    // Configuration registers, written by the user only while idle; the block does not enforce it.
    logic [TOKEN_W-1:0] r_rate;
    logic [MASK_W-1:0]  r_dmask;
    logic [TOKEN_W-1:0] w_refill;

    // Queue between the classifying front and the executing back.
    logic    w_q_valid;
    t_work   w_q_item;
    logic    w_pop;
    t_result w_out;
    logic    w_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate  <= FALLBACK_RATE;
            r_dmask <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RATE: r_rate  <= i_cfg_data;
                CFG_MASK: r_dmask <= i_cfg_data[MASK_W-1:0];
                default:  r_rate  <= r_rate;
            endcase
        end
    end

    // A rate of zero refills with the fallback value.
    assign w_refill = (r_rate == '0) ? FALLBACK_RATE : r_rate;

    psrl_front #(
        .NUM_SLOTS (NUM_SLOTS),
        .NUM_KINDS (NUM_KINDS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_command  (i_s_tuser),
        .i_slot     (i_s_tdata[2:0]),
        .i_kind     (i_s_tdata[4:3]),
        .i_new_mask (i_s_tdata[8:5]),
        .i_inherit  (i_s_tdata[9]),
        .o_q_valid  (w_q_valid),
        .o_q_item   (w_q_item),
        .i_q_pop    (w_pop)
    );

    // The back sequencer owns the masks and the token and suppressed-count store,
    // and holds each result in an output register; the front keeps accepting while the queue has room.
    psrl_back #(
        .NUM_SLOTS (NUM_SLOTS),
        .NUM_KINDS (NUM_KINDS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_q_item       (w_q_item),
        .o_q_pop        (w_pop),
        .i_refill       (w_refill),
        .i_default_mask (r_dmask),
        .o_out_valid    (w_out_valid),
        .o_out          (w_out),
        .i_out_ready    (i_m_tready)
    );

    assign o_m_tvalid = w_out_valid;
    assign o_m_tdata  = {2'b00, w_out.count, w_out.kind, w_out.slot, w_out.allowed};
    assign o_m_tuser  = w_out.rkind;
    assign o_m_tlast  = w_out.last;

`ifndef SYNTHESIS
    // The back never takes work from an empty queue.
    a_pop_needs_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("queue popped while empty");

    // A suppression report always carries a nonzero count and is never the last result.
    a_report_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == RK_REPORT) |-> (o_m_tdata[37:6] != '0 && !o_m_tlast))
        else $error("malformed suppression report");

    // Only a verdict may allow an event.
    a_allow_only_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != RK_VERDICT) |-> !o_m_tdata[0])
        else $error("allowed flag set outside a verdict");

    // The output stage is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");
`endif
endmodule
